// ===== sv/x86_control_transfer_predecode_unit_defines.svh =====
// Assertion macros used by the control-transfer predecode top level.
`ifndef X86_CONTROL_TRANSFER_PREDECODE_UNIT_DEFINES_SVH
`define X86_CONTROL_TRANSFER_PREDECODE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define XCTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define XCTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/xctp_pkg.sv =====
// Types, opcode constants and byte helpers for the control-transfer predecode.
`timescale 1ns / 1ps
package xctp_pkg;

    // Opcodes that the predecode recognizes
    localparam logic [7:0] OP_BREAK    = 8'hCC;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_CALL_REL = 8'hE8;
    localparam logic [7:0] OP_CALL_A2  = 8'hA2;
    localparam logic [7:0] OP_CALL_C8  = 8'hC8;
    localparam logic [7:0] OP_CALL_FAR = 8'h9A;
    localparam logic [7:0] OP_RET_C2   = 8'hC2;
    localparam logic [7:0] OP_RET_C3   = 8'hC3;
    localparam logic [7:0] OP_RET_CA   = 8'hCA;
    localparam logic [7:0] OP_RET_CB   = 8'hCB;
    localparam logic [7:0] OP_JMP_FAR  = 8'hEA;

    // ModRM reg field values of the FF group
    localparam logic [2:0] GRP5_CALL_NEAR = 3'd2;
    localparam logic [2:0] GRP5_CALL_FAR  = 3'd3;
    localparam logic [2:0] GRP5_JMP_NEAR  = 3'd4;
    localparam logic [2:0] GRP5_JMP_FAR   = 3'd5;

    // ModRM / SIB special codes
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;
    localparam logic [2:0] SIB_NO_IDX = 3'd4;

    typedef enum logic [1:0] {
        WK_UNKNOWN = 2'd0,
        WK_CALL    = 2'd1,
        WK_BRANCH  = 2'd2,
        WK_RETURN  = 2'd3
    } t_walk_kind;

    typedef enum logic [1:0] {
        NK_NONE    = 2'd0,
        NK_TARGET  = 2'd1,
        NK_POINTER = 2'd2
    } t_next_kind;

    typedef logic [7:0][31:0] t_reg_file;

    typedef struct packed {
        logic [31:0] instr_addr;
        logic [63:0] instr_bytes;
        logic [7:0]  patched_opcode;
        logic        regs_valid;
        logic [31:0] reg_eax;
        logic [31:0] reg_ecx;
        logic [31:0] reg_edx;
        logic [31:0] reg_ebx;
        logic [31:0] reg_esp;
        logic [31:0] reg_ebp;
        logic [31:0] reg_esi;
        logic [31:0] reg_edi;
    } t_in_word;

    typedef struct packed {
        t_walk_kind  walk_kind;
        logic        absolute_branch;
        t_next_kind  next_kind;
        logic [31:0] next_value;
        logic        skip_valid;
        logic [31:0] skip_addr;
    } t_out_word;

    // ModRM operand decode result; skip_off counts bytes from the instruction start
    typedef struct packed {
        t_next_kind  next_kind;
        logic [31:0] next_value;
        logic [3:0]  skip_off;
    } t_modrm_res;

    function automatic logic [7:0] get_byte(logic [63:0] b, logic [2:0] k);
        return b[{k, 3'b000} +: 8];
    endfunction

    // Little-endian dword, byte indexes wrap within the eight-byte window
    function automatic logic [31:0] get_u32(logic [63:0] b, logic [2:0] k);
        logic [2:0] k1;
        logic [2:0] k2;
        logic [2:0] k3;
        k1 = 3'(k + 3'd1);
        k2 = 3'(k + 3'd2);
        k3 = 3'(k + 3'd3);
        return {get_byte(b, k3), get_byte(b, k2), get_byte(b, k1), get_byte(b, k)};
    endfunction

    function automatic logic is_prefix(logic [7:0] v);
        logic r;
        case (v) inside
            8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
            8'h66, 8'h67, 8'hF0, 8'hF1, 8'hF2, 8'hF3: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/xctp_stream_if.sv =====
// Valid/ready stream channel carrying one word of type T.
`timescale 1ns / 1ps
interface xctp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/xctp_modrm.sv =====
// ModRM / SIB operand decode: pointer address or register target and operand length.
`timescale 1ns / 1ps
module xctp_modrm (
    input  logic [63:0]         i_bytes,
    input  logic [2:0]          i_pos,
    input  xctp_pkg::t_reg_file i_regs,
    input  logic                i_regs_valid,
    output xctp_pkg::t_modrm_res o_res
);
    logic [7:0]  modrm;
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic [7:0]  sib;
    logic [2:0]  sib_idx;
    logic [2:0]  sib_base;
    logic [1:0]  sib_scale;
    logic        has_sib;
    logic        has_idx;
    logic        no_base;
    logic [2:0]  p0;
    logic [2:0]  p1;
    logic [3:0]  off0;
    logic [3:0]  off1;
    logic [3:0]  off2;
    logic [31:0] idx_term;
    logic [31:0] base_term;
    logic [31:0] disp_term;
    logic [31:0] ea;
    logic [7:0]  d8;
    logic        need_reg;

    // Split the ModRM and SIB bytes
    assign modrm     = xctp_pkg::get_byte(i_bytes, i_pos);
    assign mod_f     = modrm[7:6];
    assign rm_f      = modrm[2:0];
    assign sib       = xctp_pkg::get_byte(i_bytes, 3'(i_pos + 3'd1));
    assign sib_scale = sib[7:6];
    assign sib_idx   = sib[5:3];
    assign sib_base  = sib[2:0];
    assign has_sib   = (rm_f == xctp_pkg::RM_SIB);
    assign has_idx   = has_sib && (sib_idx != xctp_pkg::SIB_NO_IDX);
    assign no_base   = (mod_f == xctp_pkg::MOD_NODISP) &&
                       (has_sib ? (sib_base == xctp_pkg::RM_DISP32)
                                : (rm_f == xctp_pkg::RM_DISP32));

    // Walk the operand bytes: SIB, base disp32, then mod displacement
    assign p0   = 3'(i_pos + 3'd1 + {2'b00, has_sib});
    assign off0 = 4'({1'b0, i_pos} + 4'd1 + {3'b000, has_sib});
    assign p1   = no_base ? 3'(p0 + 3'd4) : p0;
    assign off1 = no_base ? 4'(off0 + 4'd4) : off0;
    assign d8   = xctp_pkg::get_byte(i_bytes, p1);

    always_comb begin
        case (mod_f)
            xctp_pkg::MOD_DISP8: begin
                disp_term = {{24{d8[7]}}, d8};
                off2      = 4'(off1 + 4'd1);
            end
            xctp_pkg::MOD_DISP32: begin
                disp_term = xctp_pkg::get_u32(i_bytes, p1);
                off2      = 4'(off1 + 4'd4);
            end
            default: begin
                disp_term = '0;
                off2      = off1;
            end
        endcase
    end

    // Form the effective address from index, base and displacement
    assign idx_term  = has_idx ? (i_regs[sib_idx] << sib_scale) : '0;
    assign base_term = no_base ? xctp_pkg::get_u32(i_bytes, p0)
                               : i_regs[has_sib ? sib_base : rm_f];
    assign ea        = idx_term + base_term + disp_term;
    assign need_reg  = has_idx || !no_base;

    always_comb begin
        if (mod_f == xctp_pkg::MOD_REG) begin
            o_res.next_kind  = i_regs_valid ? xctp_pkg::NK_TARGET : xctp_pkg::NK_NONE;
            o_res.next_value = i_regs_valid ? i_regs[rm_f] : '0;
            o_res.skip_off   = 4'({1'b0, i_pos} + 4'd1);
        end else begin
            o_res.next_kind  = (need_reg && !i_regs_valid) ? xctp_pkg::NK_NONE
                                                           : xctp_pkg::NK_POINTER;
            o_res.next_value = (need_reg && !i_regs_valid) ? '0 : ea;
            o_res.skip_off   = off2;
        end
    end
endmodule

// ===== sv/xctp_classify.sv =====
// Prefix skip, breakpoint substitution and control-transfer classification.
`timescale 1ns / 1ps
module xctp_classify (
    input  xctp_pkg::t_in_word  i_word,
    output xctp_pkg::t_out_word o_word
);
    logic [63:0]          bytes;
    logic                 pfx;
    logic [2:0]           pos_op;
    logic [2:0]           pos;
    logic [7:0]           op_raw;
    logic [7:0]           op;
    logic [7:0]           modrm_b;
    logic [2:0]           grp_reg;
    logic [31:0]          imm;
    logic [31:0]          after;
    xctp_pkg::t_reg_file  regs;
    xctp_pkg::t_modrm_res mres;

    assign bytes = i_word.instr_bytes;
    assign regs  = {i_word.reg_edi, i_word.reg_esi, i_word.reg_ebp, i_word.reg_esp,
                    i_word.reg_ebx, i_word.reg_edx, i_word.reg_ecx, i_word.reg_eax};

    // Skip one prefix, then swap a breakpoint for the original opcode
    assign pfx     = xctp_pkg::is_prefix(xctp_pkg::get_byte(bytes, 3'd0));
    assign pos_op  = {2'b00, pfx};
    assign op_raw  = xctp_pkg::get_byte(bytes, pos_op);
    assign op      = (op_raw == xctp_pkg::OP_BREAK) ? i_word.patched_opcode : op_raw;
    assign pos     = 3'(pos_op + 3'd1);
    assign modrm_b = xctp_pkg::get_byte(bytes, pos);
    assign grp_reg = modrm_b[5:3];
    assign imm     = xctp_pkg::get_u32(bytes, pos);
    assign after   = i_word.instr_addr + {29'd0, pos} + 32'd4;

    xctp_modrm u_modrm (
        .i_bytes      (bytes),
        .i_pos        (pos),
        .i_regs       (regs),
        .i_regs_valid (i_word.regs_valid),
        .o_res        (mres)
    );

    // Classify the opcode and pick target and skip address
    always_comb begin
        o_word = '{walk_kind: xctp_pkg::WK_UNKNOWN, absolute_branch: 1'b0,
                   next_kind: xctp_pkg::NK_NONE, next_value: '0,
                   skip_valid: 1'b0, skip_addr: '0};
        unique case (op) inside
            xctp_pkg::OP_GRP5: begin
                if (grp_reg == xctp_pkg::GRP5_CALL_NEAR ||
                    grp_reg == xctp_pkg::GRP5_CALL_FAR) begin
                    o_word.walk_kind = xctp_pkg::WK_CALL;
                end else if (grp_reg == xctp_pkg::GRP5_JMP_NEAR ||
                             grp_reg == xctp_pkg::GRP5_JMP_FAR) begin
                    o_word.walk_kind       = xctp_pkg::WK_BRANCH;
                    o_word.absolute_branch = 1'b1;
                end
                if (grp_reg == xctp_pkg::GRP5_CALL_NEAR || grp_reg == xctp_pkg::GRP5_CALL_FAR ||
                    grp_reg == xctp_pkg::GRP5_JMP_NEAR || grp_reg == xctp_pkg::GRP5_JMP_FAR) begin
                    o_word.next_kind  = mres.next_kind;
                    o_word.next_value = mres.next_value;
                    o_word.skip_valid = 1'b1;
                    o_word.skip_addr  = i_word.instr_addr + {28'd0, mres.skip_off};
                end
            end
            xctp_pkg::OP_CALL_REL: begin
                o_word.walk_kind  = xctp_pkg::WK_CALL;
                o_word.next_kind  = xctp_pkg::NK_TARGET;
                o_word.next_value = after + imm;
                o_word.skip_valid = 1'b1;
                o_word.skip_addr  = after;
            end
            xctp_pkg::OP_CALL_A2, xctp_pkg::OP_CALL_C8, xctp_pkg::OP_CALL_FAR: begin
                o_word.walk_kind       = xctp_pkg::WK_CALL;
                o_word.absolute_branch = (op != xctp_pkg::OP_CALL_FAR);
                o_word.next_kind       = xctp_pkg::NK_TARGET;
                o_word.next_value      = imm;
                o_word.skip_valid      = 1'b1;
                o_word.skip_addr       = after;
            end
            xctp_pkg::OP_RET_C2, xctp_pkg::OP_RET_C3: begin
                o_word.walk_kind       = xctp_pkg::WK_RETURN;
                o_word.absolute_branch = 1'b1;
            end
            xctp_pkg::OP_RET_CA, xctp_pkg::OP_RET_CB: begin
                o_word.walk_kind = xctp_pkg::WK_RETURN;
            end
            xctp_pkg::OP_JMP_FAR: begin
                o_word.walk_kind       = xctp_pkg::WK_BRANCH;
                o_word.absolute_branch = 1'b1;
            end
            default: begin
                o_word.walk_kind = xctp_pkg::WK_UNKNOWN;
            end
        endcase
    end
endmodule

// ===== sv/x86_control_transfer_predecode_unit.sv =====
// Top level of the x86 control-transfer predecode: input and result registers.
//
// Usage:
//   i_in carries one instruction word per handshake: address, the first eight
//   instruction bytes, the original opcode under a breakpoint, and the eight
//   general registers with their valid flag. o_out carries one result word per
//   instruction: walk kind, absolute flag, next target kind and value, and the
//   address after the operands.
//   A word accepted into the input register is decoded into the result register, which drives o_out.
//   Throughput: one word per cycle while o_out.ready holds; the decode of an
//   instruction is a single pass of combinational logic between the input
//   register and the result register.
//   Reset (i_rst_n low, synchronous) empties both registers; o_out.valid
//   drops and i_in.ready rises in the next cycle.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; only when both are full does
//   i_in.ready fall.
`timescale 1ns / 1ps
`include "x86_control_transfer_predecode_unit_defines.svh"
module x86_control_transfer_predecode_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xctp_stream_if.sink     i_in,
    xctp_stream_if.source   o_out
);
    logic                r_s1_valid;
    xctp_pkg::t_in_word  r_s1_word;
    logic                r_out_valid;
    xctp_pkg::t_out_word r_out_word;
    xctp_pkg::t_out_word n_out_word;
    logic                s1_ready;
    logic                s2_ready;

    // Advance a stage when the stage after it is empty or moving
    assign s2_ready    = !r_out_valid || o_out.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_in.ready  = s1_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    xctp_classify u_classify (
        .i_word (r_s1_word),
        .o_word (n_out_word)
    );

    // Clear valid bits under reset, advance words when the next stage takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Capture payloads without reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && s1_ready) begin
            r_s1_word <= i_in.data;
        end
        if (r_s1_valid && s2_ready) begin
            r_out_word <= n_out_word;
        end
    end

    `XCTP_ASSERT_NEXT(a_s1_hold, r_s1_valid && r_out_valid && !o_out.ready, r_s1_valid, "input word dropped while result stalled")
    `XCTP_ASSERT_NOW(a_no_target_zero, r_out_valid && r_out_word.next_kind == xctp_pkg::NK_NONE, r_out_word.next_value == 32'd0, "next_value set without a target")
    `XCTP_ASSERT_NOW(a_no_skip_zero, r_out_valid && !r_out_word.skip_valid, r_out_word.skip_addr == 32'd0, "skip_addr set without skip_valid")
    `XCTP_ASSERT_NOW(a_unknown_clean, r_out_valid && r_out_word.walk_kind == xctp_pkg::WK_UNKNOWN, !r_out_word.absolute_branch && !r_out_word.skip_valid && r_out_word.next_kind == xctp_pkg::NK_NONE, "unknown instruction carries result fields")
endmodule
